// ----- src/midi_track_event_parser_defines.svh -----
// Assertion macros for the MIDI track event parser.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MTEP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MTEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mtep_pkg.sv -----
// Shared types and constants for the MIDI track event parser.
`default_nettype none

package mtep_pkg;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // byte values
    localparam logic [7:0] BYTE_META      = 8'hFF;
    localparam logic [7:0] BYTE_SYSEX     = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] META_EOT       = 8'h2F;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [3:0] NIB_PROGRAM    = 4'hC;
    localparam logic [3:0] NIB_PRESSURE   = 4'hD;
    localparam logic [3:0] NIB_SYSTEM     = 4'hF;

    localparam logic [2:0]  VLQ_MAX_BYTES = 3'd4;
    localparam logic [27:0] TEMPO_LEN     = 28'd3;

    typedef enum logic [3:0] {
        PH_DELTA      = 4'd0,
        PH_STATUS     = 4'd1,
        PH_DATA       = 4'd2,
        PH_META_TYPE  = 4'd3,
        PH_META_LEN   = 4'd4,
        PH_TEMPO      = 4'd5,
        PH_SKIP_META  = 4'd6,
        PH_SYSEX_LEN  = 4'd7,
        PH_SKIP_SYSEX = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        KIND_EVENT = 2'd0,
        KIND_TEMPO = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ERR_DELTA_VLQ     = 4'd0,
        ERR_EVENT_TRUNC   = 4'd1,
        ERR_META_TYPE     = 4'd2,
        ERR_META_LEN      = 4'd3,
        ERR_META_DATA     = 4'd4,
        ERR_SYSEX_LEN     = 4'd5,
        ERR_SYSEX_DATA    = 4'd6,
        ERR_NO_RUNNING    = 4'd7,
        ERR_BAD_DATA_BYTE = 4'd8
    } t_err_code;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       track_first;
        logic       track_last;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [31:0] tick;
        logic [7:0]  status_byte;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [23:0] tempo_us;
        t_err_code   error_code;
        logic        last;
    } t_result;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

`default_nettype wire

// ----- src/mtep_if.sv -----
// Handshake interfaces for the byte input and the result output.
`default_nettype none

interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       track_first;
    logic       track_last;

    modport source (output valid, output data_byte, output track_first,
                    output track_last, input ready);
    modport sink   (input valid, input data_byte, input track_first,
                    input track_last, output ready);
endinterface

interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] tick;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [23:0] tempo_us;
    logic [3:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output tick, output status_byte,
                    output first_data, output second_data, output tempo_us,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input tick, input status_byte,
                    input first_data, input second_data, input tempo_us,
                    input error_code, input last, output ready);
endinterface

`default_nettype wire

// ----- src/mtep_in_stage.sv -----
// Input register stage: holds one accepted byte until the parser takes it.
`default_nettype none

module mtep_in_stage
    import mtep_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mtep_in_if.sink   i_in,
    input  wire logic i_fire,
    output logic      o_valid,
    output t_in_item  o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || i_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte   <= i_in.data_byte;
            r_item.track_first <= i_in.track_first;
            r_item.track_last  <= i_in.track_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- src/mtep_core.sv -----
// Parser state and per-byte decode; yields up to two results per byte.
`default_nettype none

module mtep_core
    import mtep_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire t_in_item i_item,
    output t_push         o_push
);

    t_phase      r_phase, e_phase, n_phase;
    logic [31:0] r_tick, e_tick, n_tick;
    logic [7:0]  r_run, e_run, n_run;
    logic [7:0]  r_cur, e_cur, n_cur;
    logic [27:0] r_acc, e_acc, n_acc;
    logic [2:0]  r_cnt, e_cnt, n_cnt;
    logic [7:0]  r_meta, e_meta, n_meta;
    logic [27:0] r_skip, e_skip, n_skip;
    logic [6:0]  r_held, e_held, n_held;
    logic [1:0]  r_need, e_need, n_need;
    logic [23:0] r_tempo, e_tempo, n_tempo;
    logic        r_halted, e_halted, n_halted;

    logic [7:0]  b;
    logic [27:0] v_acc;
    logic [2:0]  v_cnt;
    logic        v_end, v_over;
    logic [27:0] skip_dec;

    t_result f_res, l_res;
    logic    f_vld, l_vld;

    function automatic logic [1:0] data_count(input logic [7:0] s);
        return (s[7:4] == NIB_PROGRAM || s[7:4] == NIB_PRESSURE) ? 2'd1 : 2'd2;
    endfunction

    function automatic t_err_code trunc_code(input t_phase p);
        t_err_code c;
        case (p)
            PH_DELTA:      c = ERR_DELTA_VLQ;
            PH_STATUS:     c = ERR_EVENT_TRUNC;
            PH_DATA:       c = ERR_BAD_DATA_BYTE;
            PH_META_TYPE:  c = ERR_META_TYPE;
            PH_META_LEN:   c = ERR_META_LEN;
            PH_TEMPO:      c = ERR_META_DATA;
            PH_SKIP_META:  c = ERR_META_DATA;
            PH_SYSEX_LEN:  c = ERR_SYSEX_LEN;
            PH_SKIP_SYSEX: c = ERR_SYSEX_DATA;
            default:       c = ERR_EVENT_TRUNC;
        endcase
        return c;
    endfunction

    function automatic t_result mk_simple(input t_kind k, input t_err_code c);
        t_result r;
        r            = '0;
        r.kind       = k;
        r.error_code = c;
        return r;
    endfunction

    function automatic t_result mk_event(input logic [31:0] t, input logic [7:0] s,
                                         input logic [6:0] d1, input logic [6:0] d2);
        t_result r;
        r             = '0;
        r.kind        = KIND_EVENT;
        r.tick        = t;
        r.status_byte = s;
        r.first_data  = d1;
        r.second_data = d2;
        return r;
    endfunction

    function automatic t_result mk_tempo(input logic [31:0] t, input logic [23:0] us);
        t_result r;
        r          = '0;
        r.kind     = KIND_TEMPO;
        r.tick     = t;
        r.tempo_us = us;
        return r;
    endfunction

    // a first-of-track byte sees freshly cleared state
    always_comb begin
        if (i_item.track_first) begin
            e_phase  = PH_DELTA;
            e_tick   = '0;
            e_run    = '0;
            e_cur    = '0;
            e_acc    = '0;
            e_cnt    = '0;
            e_meta   = '0;
            e_skip   = '0;
            e_held   = '0;
            e_need   = '0;
            e_tempo  = '0;
            e_halted = 1'b0;
        end else begin
            e_phase  = r_phase;
            e_tick   = r_tick;
            e_run    = r_run;
            e_cur    = r_cur;
            e_acc    = r_acc;
            e_cnt    = r_cnt;
            e_meta   = r_meta;
            e_skip   = r_skip;
            e_held   = r_held;
            e_need   = r_need;
            e_tempo  = r_tempo;
            e_halted = r_halted;
        end
    end

    // variable-length quantity step
    assign b        = i_item.data_byte;
    assign v_acc    = {e_acc[20:0], b[6:0]};
    assign v_cnt    = e_cnt + 3'd1;
    assign v_end    = !b[7];
    assign v_over   = b[7] && (v_cnt >= VLQ_MAX_BYTES);
    assign skip_dec = (e_skip != '0) ? e_skip - 28'd1 : e_skip;

    // next state
    always_comb begin
        n_phase  = e_phase;
        n_tick   = e_tick;
        n_run    = e_run;
        n_cur    = e_cur;
        n_acc    = e_acc;
        n_cnt    = e_cnt;
        n_meta   = e_meta;
        n_skip   = e_skip;
        n_held   = e_held;
        n_need   = e_need;
        n_tempo  = e_tempo;
        n_halted = e_halted;
        f_vld    = 1'b0;
        f_res    = '0;
        l_vld    = 1'b0;
        l_res    = '0;

        if (!e_halted) begin
            case (e_phase)
                PH_DELTA: begin
                    n_acc = v_acc;
                    n_cnt = v_cnt;
                    if (v_end) begin
                        n_tick  = e_tick + {4'd0, v_acc};
                        n_phase = PH_STATUS;
                    end else if (v_over) begin
                        f_vld    = 1'b1;
                        f_res    = mk_simple(KIND_ERROR, ERR_DELTA_VLQ);
                        n_halted = 1'b1;
                    end
                end
                PH_STATUS: begin
                    if (b == BYTE_META) begin
                        n_phase = PH_META_TYPE;
                    end else if (b == BYTE_SYSEX || b == BYTE_SYSEX_ESC) begin
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_phase = PH_SYSEX_LEN;
                    end else if (b[7]) begin
                        n_cur = b;
                        if (b[7:4] != NIB_SYSTEM) begin
                            n_run = b;
                        end
                        n_need  = data_count(b);
                        n_phase = PH_DATA;
                    end else if (e_run == '0) begin
                        f_vld    = 1'b1;
                        f_res    = mk_simple(KIND_ERROR, ERR_NO_RUNNING);
                        n_halted = 1'b1;
                    end else begin
                        n_cur  = e_run;
                        n_held = b[6:0];
                        if (data_count(e_run) == 2'd1) begin
                            f_vld   = 1'b1;
                            f_res   = mk_event(e_tick, e_run, b[6:0], 7'd0);
                            n_phase = PH_DELTA;
                            n_acc   = '0;
                            n_cnt   = '0;
                        end else begin
                            n_need  = 2'd1;
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    if (b[7]) begin
                        f_vld    = 1'b1;
                        f_res    = mk_simple(KIND_ERROR, ERR_BAD_DATA_BYTE);
                        n_halted = 1'b1;
                    end else if (e_need >= 2'd2) begin
                        n_held = b[6:0];
                        n_need = 2'd1;
                    end else begin
                        // system common messages are consumed silently
                        f_vld = (e_cur[7:4] != NIB_SYSTEM);
                        if (data_count(e_cur) == 2'd1) begin
                            f_res = mk_event(e_tick, e_cur, b[6:0], 7'd0);
                        end else begin
                            f_res = mk_event(e_tick, e_cur, e_held, b[6:0]);
                        end
                        n_phase = PH_DELTA;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end
                end
                PH_META_TYPE: begin
                    n_meta  = b;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_META_LEN;
                end
                PH_META_LEN: begin
                    n_acc = v_acc;
                    n_cnt = v_cnt;
                    if (v_over) begin
                        f_vld    = 1'b1;
                        f_res    = mk_simple(KIND_ERROR, ERR_META_LEN);
                        n_halted = 1'b1;
                    end else if (v_end) begin
                        if (e_meta == META_EOT) begin
                            f_vld    = 1'b1;
                            f_res    = mk_simple(KIND_DONE, ERR_DELTA_VLQ);
                            n_halted = 1'b1;
                        end else if (e_meta == META_TEMPO && v_acc == TEMPO_LEN) begin
                            n_tempo = '0;
                            n_skip  = TEMPO_LEN;
                            n_phase = PH_TEMPO;
                        end else if (v_acc == '0) begin
                            n_acc   = '0;
                            n_cnt   = '0;
                            n_phase = PH_DELTA;
                        end else begin
                            n_skip  = v_acc;
                            n_phase = PH_SKIP_META;
                        end
                    end
                end
                PH_TEMPO: begin
                    n_tempo = {e_tempo[15:0], b};
                    n_skip  = skip_dec;
                    if (skip_dec == '0) begin
                        f_vld   = 1'b1;
                        f_res   = mk_tempo(e_tick, {e_tempo[15:0], b});
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_phase = PH_DELTA;
                    end
                end
                PH_SYSEX_LEN: begin
                    n_acc = v_acc;
                    n_cnt = v_cnt;
                    if (v_over) begin
                        f_vld    = 1'b1;
                        f_res    = mk_simple(KIND_ERROR, ERR_SYSEX_LEN);
                        n_halted = 1'b1;
                    end else if (v_end) begin
                        if (v_acc == '0) begin
                            n_acc   = '0;
                            n_cnt   = '0;
                            n_phase = PH_DELTA;
                        end else begin
                            n_skip  = v_acc;
                            n_phase = PH_SKIP_SYSEX;
                        end
                    end
                end
                PH_SKIP_META, PH_SKIP_SYSEX: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_phase = PH_DELTA;
                    end
                end
                default: begin
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_DELTA;
                end
            endcase
        end

        // end of chunk: clean only between items
        if (i_item.track_last && !n_halted) begin
            l_vld = 1'b1;
            if (n_phase == PH_DELTA && n_cnt == '0) begin
                l_res = mk_simple(KIND_DONE, ERR_DELTA_VLQ);
            end else begin
                l_res = mk_simple(KIND_ERROR, trunc_code(n_phase));
            end
            n_halted = 1'b1;
        end
    end

    // results handed to the queue
    always_comb begin
        o_push         = '0;
        o_push.cnt     = i_fire ? ({1'b0, f_vld} + {1'b0, l_vld}) : 2'd0;
        o_push.r0      = f_vld ? f_res : l_res;
        o_push.r0.last = !(f_vld && l_vld);
        o_push.r1      = l_res;
        o_push.r1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DELTA;
            r_tick   <= '0;
            r_run    <= '0;
            r_cur    <= '0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_meta   <= '0;
            r_skip   <= '0;
            r_held   <= '0;
            r_need   <= '0;
            r_tempo  <= '0;
            r_halted <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_run    <= n_run;
            r_cur    <= n_cur;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_meta   <= n_meta;
            r_skip   <= n_skip;
            r_held   <= n_held;
            r_need   <= n_need;
            r_tempo  <= n_tempo;
            r_halted <= n_halted;
        end
    end

endmodule

`default_nettype wire

// ----- src/mtep_res_queue.sv -----
// Result queue: takes up to two results a cycle, hands out one.
`default_nettype none

module mtep_res_queue
    import mtep_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    mtep_out_if.source o_out
);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic                pop;
    t_result             head;

    assign head  = r_mem[r_rd];
    assign pop   = o_out.valid && o_out.ready;
    // space for the worst case of two results
    assign o_room = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));

    assign o_out.valid       = (r_count != '0);
    assign o_out.kind        = head.kind;
    assign o_out.tick        = head.tick;
    assign o_out.status_byte = head.status_byte;
    assign o_out.first_data  = head.first_data;
    assign o_out.second_data = head.second_data;
    assign o_out.tempo_us    = head.tempo_us;
    assign o_out.error_code  = head.error_code;
    assign o_out.last        = head.last;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + QPTR_W'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QPTR_W'(i_push.cnt);
            r_rd    <= r_rd + QPTR_W'(pop);
            r_count <= r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// ----- src/midi_track_event_parser.sv -----
// Top level of the MIDI track event parser.
//
// Parses the body of a standard MIDI file track chunk, one byte per item.
// Rate: one byte is taken every clock cycle as long as results drain; a
// byte that yields two results (the last channel event of a chunk followed
// by its track-done mark, say) pushes both at once, and a four-entry
// result queue absorbs such bursts. The pace is set by the single decode
// pass between the input register and the queue. Delta times are
// variable-length quantities of up to four bytes added to a wrapping
// 32-bit tick; running status is applied; channel events and tempo
// changes (meta 0x51 of length 3) are reported, other meta, sysex and
// system common data are skipped. End-of-track, a truncated chunk or a
// malformed item ends the track, and every byte after that is dropped
// until the next byte flagged track_first, which clears tick, running
// status and parse state.
`default_nettype none

`include "midi_track_event_parser_defines.svh"

module midi_track_event_parser
    import mtep_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mtep_in_if.sink    i_in,
    mtep_out_if.source o_out
);

    // input register -> decode/state -> result queue
    logic     w_in_valid;
    t_in_item w_in_item;
    logic     w_room;
    logic     w_fire;
    t_push    w_push;

    // the held byte is decoded once the queue has space for two results
    assign w_fire = w_in_valid && w_room;

    mtep_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_fire  (w_fire),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    mtep_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (w_in_item),
        .o_push  (w_push)
    );

    mtep_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_out   (o_out)
    );

    // a byte waiting for room in the queue is neither lost nor altered
    `MTEP_ASSERT_NEXT(a_held_byte_kept, i_clk, i_rst_n, w_in_valid && !w_fire, w_in_valid && $stable(w_in_item), "held byte lost or changed")

    // only the end-of-chunk check can add a second result to a byte
    `MTEP_ASSERT_SAME(a_second_is_track_end, i_clk, i_rst_n, w_push.cnt == 2'd2, w_push.r1.kind == KIND_DONE || w_push.r1.kind == KIND_ERROR, "second result is not a track end")

    // channel events carry a channel status byte
    `MTEP_ASSERT_SAME(a_event_status, i_clk, i_rst_n, o_out.valid && o_out.kind == KIND_EVENT, o_out.status_byte[7] && o_out.status_byte[7:4] != NIB_SYSTEM, "event without channel status")

endmodule

`default_nettype wire

// ----- tb/midi_track_event_parser_checker.sv -----
// Result checker for the MIDI track event parser: predicts each byte's results and compares.
`default_nettype none

module midi_track_event_parser_checker
    import mtep_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mtep_in_if        i_bytes,
    mtep_out_if       i_results,
    output int        o_mismatches,
    output int        o_results_due
);

    localparam logic [1:0] VLQ_MORE = 2'd0;
    localparam logic [1:0] VLQ_DONE = 2'd1;
    localparam logic [1:0] VLQ_OVER = 2'd2;
    localparam t_err_code  NO_ERR   = ERR_DELTA_VLQ;  // code field reads zero off errors
    localparam int         REPORT_MAX = 10;

    // parser state as predicted
    t_phase      phase;
    logic [31:0] tick_now;
    logic [7:0]  running_st;
    logic [7:0]  event_st;
    logic [31:0] vlq_value;
    logic [2:0]  vlq_bytes;
    logic [7:0]  meta_type;
    logic [27:0] bytes_left;
    logic [7:0]  first_held;
    logic [1:0]  data_left;
    logic [23:0] tempo_value;
    logic        halted;

    t_result byte_results[2];
    int      byte_result_cnt;
    t_result awaited_results[$];

    function automatic void clear_track();
        phase       = PH_DELTA;
        tick_now    = '0;
        running_st  = '0;
        event_st    = '0;
        vlq_value   = '0;
        vlq_bytes   = '0;
        meta_type   = '0;
        bytes_left  = '0;
        first_held  = '0;
        data_left   = '0;
        tempo_value = '0;
        halted      = 1'b0;
    endfunction

    function automatic void note_result(t_kind k, logic [31:0] tk, logic [7:0] st,
                                        logic [6:0] d1, logic [6:0] d2,
                                        logic [23:0] tu, t_err_code ec);
        t_result r;
        r.kind        = k;
        r.tick        = tk;
        r.status_byte = st;
        r.first_data  = d1;
        r.second_data = d2;
        r.tempo_us    = tu;
        r.error_code  = ec;
        r.last        = 1'b0;
        byte_results[byte_result_cnt] = r;
        byte_result_cnt++;
    endfunction

    function automatic void halt_with(t_err_code ec);
        note_result(KIND_ERROR, '0, '0, '0, '0, '0, ec);
        halted = 1'b1;
    endfunction

    function automatic void restart_vlq(t_phase nxt);
        vlq_value = '0;
        vlq_bytes = '0;
        phase     = nxt;
    endfunction

    function automatic logic [1:0] vlq_take(logic [7:0] b);
        vlq_value = {vlq_value[24:0], b[6:0]};
        vlq_bytes = vlq_bytes + 3'd1;
        if (!b[7])
            return VLQ_DONE;
        return (vlq_bytes >= VLQ_MAX_BYTES) ? VLQ_OVER : VLQ_MORE;
    endfunction

    function automatic logic [1:0] data_bytes_for(logic [7:0] st);
        return (st[7:4] == NIB_PROGRAM || st[7:4] == NIB_PRESSURE) ? 2'd1 : 2'd2;
    endfunction

    function automatic void close_event(logic [6:0] d1, logic [6:0] d2);
        if (event_st[7:4] != NIB_SYSTEM)
            note_result(KIND_EVENT, tick_now, event_st, d1, d2, '0, NO_ERR);
        restart_vlq(PH_DELTA);
    endfunction

    function automatic t_err_code cut_short_code();
        case (phase)
            PH_DELTA:      return ERR_DELTA_VLQ;
            PH_STATUS:     return ERR_EVENT_TRUNC;
            PH_DATA:       return ERR_BAD_DATA_BYTE;
            PH_META_TYPE:  return ERR_META_TYPE;
            PH_META_LEN:   return ERR_META_LEN;
            PH_TEMPO:      return ERR_META_DATA;
            PH_SKIP_META:  return ERR_META_DATA;
            PH_SYSEX_LEN:  return ERR_SYSEX_LEN;
            PH_SKIP_SYSEX: return ERR_SYSEX_DATA;
            default:       return ERR_EVENT_TRUNC;
        endcase
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        logic [1:0] v;
        case (phase)
            PH_DELTA: begin
                v = vlq_take(b);
                if (v == VLQ_DONE) begin
                    tick_now = tick_now + vlq_value;
                    phase    = PH_STATUS;
                end else if (v == VLQ_OVER) begin
                    halt_with(ERR_DELTA_VLQ);
                end
            end
            PH_STATUS: begin
                if (b == BYTE_META) begin
                    phase = PH_META_TYPE;
                end else if (b == BYTE_SYSEX || b == BYTE_SYSEX_ESC) begin
                    restart_vlq(PH_SYSEX_LEN);
                end else if (b[7]) begin
                    event_st = b;
                    if (b[7:4] != NIB_SYSTEM)
                        running_st = b;
                    data_left = data_bytes_for(b);
                    phase     = PH_DATA;
                end else if (running_st == '0) begin
                    halt_with(ERR_NO_RUNNING);
                end else begin
                    event_st   = running_st;
                    first_held = b;
                    if (data_bytes_for(event_st) == 2'd1) begin
                        close_event(b[6:0], '0);
                    end else begin
                        data_left = 2'd1;
                        phase     = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (b[7])
                    halt_with(ERR_BAD_DATA_BYTE);
                else if (data_left >= 2'd2) begin
                    first_held = b;
                    data_left  = 2'd1;
                end else if (data_bytes_for(event_st) == 2'd1)
                    close_event(b[6:0], '0);
                else
                    close_event(first_held[6:0], b[6:0]);
            end
            PH_META_TYPE: begin
                meta_type = b;
                restart_vlq(PH_META_LEN);
            end
            PH_META_LEN: begin
                v = vlq_take(b);
                if (v == VLQ_OVER) begin
                    halt_with(ERR_META_LEN);
                end else if (v == VLQ_DONE) begin
                    if (meta_type == META_EOT) begin
                        note_result(KIND_DONE, '0, '0, '0, '0, '0, NO_ERR);
                        halted = 1'b1;
                    end else if (meta_type == META_TEMPO && vlq_value == 32'd3) begin
                        tempo_value = '0;
                        bytes_left  = TEMPO_LEN;
                        phase       = PH_TEMPO;
                    end else if (vlq_value == '0) begin
                        restart_vlq(PH_DELTA);
                    end else begin
                        bytes_left = vlq_value[27:0];
                        phase      = PH_SKIP_META;
                    end
                end
            end
            PH_TEMPO: begin
                tempo_value = {tempo_value[15:0], b};
                if (bytes_left != '0)
                    bytes_left = bytes_left - 28'd1;
                if (bytes_left == '0) begin
                    note_result(KIND_TEMPO, tick_now, '0, '0, '0, tempo_value, NO_ERR);
                    restart_vlq(PH_DELTA);
                end
            end
            PH_SYSEX_LEN: begin
                v = vlq_take(b);
                if (v == VLQ_OVER) begin
                    halt_with(ERR_SYSEX_LEN);
                end else if (v == VLQ_DONE) begin
                    if (vlq_value == '0) begin
                        restart_vlq(PH_DELTA);
                    end else begin
                        bytes_left = vlq_value[27:0];
                        phase      = PH_SKIP_SYSEX;
                    end
                end
            end
            PH_SKIP_META, PH_SKIP_SYSEX: begin
                if (bytes_left != '0)
                    bytes_left = bytes_left - 28'd1;
                if (bytes_left == '0)
                    restart_vlq(PH_DELTA);
            end
            default: restart_vlq(PH_DELTA);
        endcase
    endfunction

    function automatic void take_item(logic [7:0] b, logic first, logic last_mark);
        byte_result_cnt = 0;
        if (first)
            clear_track();
        if (!halted)
            parse_byte(b);
        if (last_mark && !halted) begin
            if (phase == PH_DELTA && vlq_bytes == '0)
                note_result(KIND_DONE, '0, '0, '0, '0, '0, NO_ERR);
            else
                note_result(KIND_ERROR, '0, '0, '0, '0, '0, cut_short_code());
            halted = 1'b1;
        end
        if (byte_result_cnt > 0)
            byte_results[byte_result_cnt - 1].last = 1'b1;
        for (int i = 0; i < byte_result_cnt; i++)
            awaited_results.push_back(byte_results[i]);
    endfunction

    task automatic flag_result(bit known, t_result want);
        o_mismatches++;
        if (o_mismatches <= REPORT_MAX) begin
            if (known)
                $display("result mismatch, expected k=%0d t=%h s=%h d=%h,%h tu=%h e=%0d l=%b",
                         want.kind, want.tick, want.status_byte, want.first_data,
                         want.second_data, want.tempo_us, want.error_code, want.last);
            else
                $display("result arrived with nothing expected");
            $display("  actual k=%0d t=%h s=%h d=%h,%h tu=%h e=%0d l=%b",
                     i_results.kind, i_results.tick, i_results.status_byte,
                     i_results.first_data, i_results.second_data, i_results.tempo_us,
                     i_results.error_code, i_results.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_track();
            awaited_results.delete();
            o_mismatches = 0;
        end else begin
            // prediction first: a result never leaves in its own byte's cycle
            if (i_bytes.valid && i_bytes.ready)
                take_item(i_bytes.data_byte, i_bytes.track_first, i_bytes.track_last);
            if (i_results.valid && i_results.ready) begin
                if (awaited_results.size() == 0) begin
                    flag_result(1'b0, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_results.kind !== want.kind || i_results.tick !== want.tick ||
                        i_results.status_byte !== want.status_byte ||
                        i_results.first_data !== want.first_data ||
                        i_results.second_data !== want.second_data ||
                        i_results.tempo_us !== want.tempo_us ||
                        i_results.error_code !== want.error_code ||
                        i_results.last !== want.last)
                        flag_result(1'b1, want);
                end
            end
        end
        o_results_due = awaited_results.size();
    end

endmodule

`default_nettype wire

// ----- tb/midi_track_event_parser_test.sv -----
// Testbench top for the MIDI track event parser: stimulus, back-pressure and verdict.
`default_nettype none

module midi_track_event_parser_test;
    import mtep_pkg::*;

    localparam int ITEM_TARGET  = 1700;    // random bytes to send
    localparam int CALM_TAIL    = 200;     // last bytes go with no idling at all
    localparam int CYCLE_LIMIT  = 400000;  // well above the slowest legal run
    localparam int DRAIN_CYCLES = 20;      // settle time after the last result

    logic i_clk;
    logic i_rst_n;

    int   cycle_count = 0;
    int   mismatches;
    int   results_due;
    int   items_sent  = 0;
    int   stall_left  = 0;
    int   track_count = 0;
    bit   feed_gaps    = 1'b0;   // sender may leave holes between bytes
    bit   drain_stalls = 1'b0;   // result side may drop ready

    // bytes of the track under construction, and its running status so that
    // well-formed running-status events get the right number of data bytes
    logic [7:0] track_bytes[$];
    logic [7:0] stim_running;

    mtep_in_if  byte_ch();
    mtep_out_if result_ch();

    midi_track_event_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (result_ch)
    );

    midi_track_event_parser_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bytes       (byte_ch),
        .i_results     (result_ch),
        .o_mismatches  (mismatches),
        .o_results_due (results_due)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Hard stop: only reached if the parser hangs or drops results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result back-pressure: random stall bursts while enabled.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end else if (drain_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 11);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // One byte over the input channel. Called at a falling edge, returns at the
    // falling edge after acceptance with valid still high, so back-to-back
    // bytes never see valid lowered and raised in one step.
    task automatic send_item(logic [7:0] b, logic first, logic last_mark);
        if (feed_gaps && $urandom_range(0, 4) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.track_first <= first;
        byte_ch.track_last  <= last_mark;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off until the checker has seen every predicted result.
    task automatic wait_drained();
        while (results_due != 0) @(negedge i_clk);
    endtask

    // Sends the built track with first/last marks on its ends; trailing
    // junk after end-of-track is ignored by the parser and not counted.
    task automatic send_track(int junk);
        int n;
        n = track_bytes.size();
        for (int i = 0; i < n; i++)
            send_item(track_bytes[i], i == 0, i == n - 1);
        items_sent += n - junk;
    endtask

    // A burst of raw bytes with random marks: stray firsts, lasts, both.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom()), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        items_sent += n;
    endtask

    function automatic void put(logic [7:0] b);
        track_bytes.push_back(b);
    endfunction

    // Variable-length quantity in exactly n bytes; leading zero groups are legal.
    function automatic void put_vlq(logic [27:0] v, int n);
        logic [27:0] sh;
        for (int i = n - 1; i >= 0; i--) begin
            sh = v >> (7 * i);
            put({i != 0, sh[6:0]});
        end
    endfunction

    function automatic logic [7:0] data_val();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return {1'b0, 7'($urandom())};
        endcase
    endfunction

    function automatic int data_len(logic [7:0] st);
        return (st[7:4] == NIB_PROGRAM || st[7:4] == NIB_PRESSURE) ? 1 : 2;
    endfunction

    function automatic void put_delta();
        int          sel;
        int          n;
        logic [27:0] mask;
        sel = $urandom_range(0, 99);
        if (sel < 2) begin
            // overlong: four bytes all carrying a continuation bit
            repeat (4) put(8'h80 | 8'($urandom()));
        end else if (sel >= 98) begin
            put_vlq(28'hFFFFFFF, 4);
        end else begin
            n = (sel < 70) ? 1 : (sel < 85) ? 2 : (sel < 93) ? 3 : 4;
            mask = (28'd1 << (7 * n)) - 28'd1;
            put_vlq(28'($urandom()) & mask, n);
        end
    endfunction

    // Length field of a meta or sysex item; returns how many body bytes follow.
    function automatic int put_length();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 2) begin
            repeat (4) put(8'h80 | 8'($urandom()));
            return 0;
        end else if (sel < 5) begin
            // far more body than the track holds: ends in truncation
            put_vlq(28'($urandom()), 4);
            return 0;
        end
        len = $urandom_range(0, 6);
        put_vlq(28'(len), $urandom_range(1, 2));
        return len;
    endfunction

    function automatic void put_channel();
        logic [7:0] st;
        if (stim_running != 8'h00 && $urandom_range(0, 2) == 0) begin
            st = stim_running;
        end else begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            put(st);
            stim_running = st;
        end
        repeat (data_len(st)) put(data_val());
    endfunction

    function automatic void put_tempo();
        int sel;
        put(BYTE_META);
        put(META_TEMPO);
        put(8'h03);
        sel = $urandom_range(0, 9);
        repeat (3) put(sel == 0 ? 8'h00 : sel == 1 ? 8'hFF : 8'($urandom()));
    endfunction

    function automatic void put_meta_other();
        logic [7:0] mt;
        int         len;
        mt = {1'b0, 7'($urandom())};
        if (mt == META_EOT)
            mt = META_TEMPO;    // tempo type with whatever length follows
        put(BYTE_META);
        put(mt);
        len = put_length();
        repeat (len) put(8'($urandom()));
    endfunction

    function automatic void put_sysex();
        int len;
        put($urandom_range(0, 1) ? BYTE_SYSEX : BYTE_SYSEX_ESC);
        len = put_length();
        repeat (len) put(8'($urandom()));
    endfunction

    function automatic void put_system_common();
        logic [7:0] st;
        st = 8'($urandom_range(8'hF1, 8'hFE));
        if (st == BYTE_SYSEX_ESC)
            st = 8'hF1;
        put(st);
        repeat (2) put(data_val());
    endfunction

    function automatic void put_eot();
        put(BYTE_META);
        put(META_EOT);
        put(8'($urandom_range(0, 2)));
    endfunction

    // Builds one track into track_bytes; returns the count of junk bytes
    // placed after end-of-track.
    function automatic int build_track(bit long_haul);
        int sel;
        int junk;
        int cut;
        track_bytes.delete();
        stim_running = 8'h00;
        junk = 0;
        if (long_haul) begin
            // twenty maximal deltas carry the tick through its wrap
            repeat (20) begin
                put_vlq(28'hFFFFFFF, 4);
                put({NIB_PROGRAM, 4'($urandom())});
                put(data_val());
            end
            put(8'h00);
            put_eot();
            return 0;
        end
        repeat ($urandom_range(1, 8)) begin
            put_delta();
            sel = $urandom_range(0, 99);
            if (sel < 55)
                put_channel();
            else if (sel < 67)
                put_tempo();
            else if (sel < 79)
                put_meta_other();
            else if (sel < 90)
                put_sysex();
            else
                put_system_common();
        end
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            put_delta();
            put_eot();
            junk = $urandom_range(0, 3);
            repeat (junk) put(8'($urandom()));
        end else if (sel >= 8) begin
            cut = $urandom_range(1, track_bytes.size());
            while (track_bytes.size() > cut) void'(track_bytes.pop_back());
        end
        // occasional corrupted byte anywhere in the track
        if ($urandom_range(0, 5) == 0)
            track_bytes[$urandom_range(0, track_bytes.size() - 1)] = 8'($urandom());
        return junk;
    endfunction

    initial begin
        bit calm;
        int junk;

        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = 8'h00;
        byte_ch.track_first = 1'b0;
        byte_ch.track_last  = 1'b0;
        result_ch.ready     = 1'b0;
        i_rst_n             = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed track: note on, running status after a two-byte delta,
        // maximal four-byte delta with program change, tempo change, then
        // end-of-track with the chunk's last mark on its final byte.
        track_bytes = '{8'h00, 8'h90, 8'h3C, 8'h7F,
                        8'h81, 8'h00, 8'h3C, 8'h00,
                        8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hC5, 8'h7F,
                        8'h00, BYTE_META, META_TEMPO, 8'h03, 8'h07, 8'hA1, 8'h20,
                        8'h00, BYTE_META, META_EOT, 8'h00};
        send_track(0);
        // one-byte track with both marks: unfinished delta
        send_item(8'h80, 1'b1, 1'b1);
        // data byte with no running status
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h45, 1'b0, 1'b1);
        // status byte where a data byte belongs
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h90, 1'b0, 1'b0);
        send_item(8'hC0, 1'b0, 1'b1);
        wait_drained();

        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            calm         = items_sent >= ITEM_TARGET - CALM_TAIL;
            feed_gaps    = !calm && $urandom_range(0, 2) != 0;
            drain_stalls = !calm && $urandom_range(0, 2) != 0;
            if (!calm && $urandom_range(0, 9) == 0)
                wait_drained();
            track_count++;
            if (!calm && $urandom_range(0, 14) == 0) begin
                send_noise();
            end else begin
                junk = build_track(track_count == 3 || track_count == 60);
                send_track(junk);
            end
        end

        byte_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
